FILE: design/aalc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the square-root step for the line coverage block.
// No dependencies.
package aalc_pkg;

	localparam int FRAC      = 4;            // coordinate fraction bits
	localparam int ONE       = 1 << FRAC;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam int NST       = 14;           // pipeline stages
	localparam int SQ_FIRST  = 6;            // first root stage
	localparam int SQ_STAGES = 6;
	localparam int SQ_ITER   = 5;            // root digits per stage
	localparam int FULL_COV  = (2 * ONE) << 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X   = 3'd0,
		REG_START_Y   = 3'd1,
		REG_END_X     = 3'd2,
		REG_END_Y     = 3'd3,
		REG_THICKNESS = 3'd4,
		REG_COLOR     = 3'd5
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQX  = 5'b00010,
		ST_SQY  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DIV  = 5'b10000
	} cfg_st_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	// One digit of the restoring square root.
	function automatic sq_t sqrt_step(sq_t a, logic [1:0] b);
		sq_t         r;
		logic [35:0] rm;
		logic [35:0] trial;
		rm    = {a.rem[33:0], b};
		trial = {2'b00, a.root, 2'b01};
		if (rm >= trial) begin
			r.rem  = rm - trial;
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = rm;
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: design/antialiased_line_coverage.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while setup is idle and m_tready does not stall the output.
// After reset and after every register write, the segment length and unit direction
// are rebuilt by a serial root and a serial divider, and s_tready stays low until both finish.
// Reset loads endpoints 0, thickness 16, color 255, empties the pipeline.
// Depends on aalc_pkg.
module antialiased_line_coverage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // pixel_col, pixel_row
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,   // out_col, out_row, red, green, blue, alpha
	output logic                           m_tuser,   // draw_pixel
	input  logic                           cfg_we,
	input  logic [aalc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aalc_pkg::CFG_W-1:0]     cfg_data
);
	import aalc_pkg::*;

	logic [19:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [11:0] thick_q;
	logic [31:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			thick_q   <= 12'd16;
			color_q   <= 32'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:   start_x_q <= cfg_data[19:0];
				REG_START_Y:   start_y_q <= cfg_data[19:0];
				REG_END_X:     end_x_q   <= cfg_data[19:0];
				REG_END_Y:     end_y_q   <= cfg_data[19:0];
				REG_THICKNESS: thick_q   <= cfg_data[11:0];
				REG_COLOR:     color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment setup: length by serial root, direction by serial divide
	logic signed [21:0] dx, dy;
	logic        [21:0] adx, ady;
	assign dx  = $signed({end_x_q[19], end_x_q, 1'b0}) - $signed({start_x_q[19], start_x_q, 1'b0});
	assign dy  = $signed({end_y_q[19], end_y_q, 1'b0}) - $signed({start_y_q[19], start_y_q, 1'b0});
	assign adx = dx[21] ? 22'(-dx) : 22'(dx);
	assign ady = dy[21] ? 22'(-dy) : 22'(dy);

	cfg_st_t     state_q;
	logic [5:0]  cnt_q;
	logic [43:0] sqx_q;
	logic [43:0] len2;
	logic [63:0] rad_q;
	sq_t         rt_q, rt_nxt;
	logic [47:0] numx_q, numy_q;
	logic [32:0] remx_q, remy_q;
	logic [32:0] trx, try_, dvs;
	logic        lenz_q;
	logic signed [18:0] ux_q, uy_q;
	logic        busy;

	assign busy   = (state_q != ST_IDLE);
	assign len2   = sqx_q + ady * ady;
	assign rt_nxt = sqrt_step(rt_q, rad_q[63:62]);
	assign dvs    = {1'b0, rt_q.root};
	assign trx    = {remx_q[31:0], numx_q[47]};
	assign try_   = {remy_q[31:0], numy_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SQX;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_SQX;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_ROOT;
				ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: state_q <= ST_SQX;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ux_q <= dx[21] ? -$signed(numx_q[18:0]) : $signed(numx_q[18:0]);
				uy_q <= dy[21] ? -$signed(numy_q[18:0]) : $signed(numy_q[18:0]);
			end
			ST_SQX: sqx_q <= adx * adx;
			ST_SQY: begin
				rad_q   <= {len2, 20'b0};
				rt_q    <= '0;
				lenz_q  <= (len2 == '0);
				numx_q  <= {adx, 26'b0};
				numy_q  <= {ady, 26'b0};
				remx_q  <= '0;
				remy_q  <= '0;
			end
			ST_ROOT: begin
				rt_q  <= rt_nxt;
				rad_q <= {rad_q[61:0], 2'b00};
			end
			ST_DIV: begin
				// quotient bits shift into the numerator register
				if (trx >= dvs) begin
					remx_q <= trx - dvs;
					numx_q <= {numx_q[46:0], 1'b1};
				end else begin
					remx_q <= trx;
					numx_q <= {numx_q[46:0], 1'b0};
				end
				if (try_ >= dvs) begin
					remy_q <= try_ - dvs;
					numy_q <= {numy_q[46:0], 1'b1};
				end else begin
					remy_q <= try_;
					numy_q <= {numy_q[46:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Pixel pipeline: stage k loads when empty or when stage k+1 loads
	logic [NST-1:0] vld_q, en;

	always_comb begin
		en[NST-1] = ~vld_q[NST-1] | m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	assign s_tready = en[0] & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_tvalid & ~busy;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	logic [15:0] pcol_q [NST];
	logic [15:0] prow_q [NST];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pcol_q[0] <= s_tdata[15:0];
			prow_q[0] <= s_tdata[31:16];
		end
		for (int k = 1; k < NST; k++) begin
			if (en[k]) begin
				pcol_q[k] <= pcol_q[k-1];
				prow_q[k] <= prow_q[k-1];
			end
		end
	end

	// s1: sample offset from the start point
	logic signed [22:0] ax_s1, ay_s1;
	logic signed [20:0] sx, sy;
	assign sx = $signed({start_x_q, 1'b0});
	assign sy = $signed({start_y_q, 1'b0});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ax_s1 <= (23'($signed(s_tdata[15:0])) <<< (FRAC + 1)) + 23'(ONE) - 23'(sx);
			ay_s1 <= (23'($signed(s_tdata[31:16])) <<< (FRAC + 1)) + 23'(ONE) - 23'(sy);
		end
	end

	// s2: projections onto the unit direction
	logic signed [41:0] pa_s2, pb_s2, pc_s2, pd_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pa_s2 <= ax_s1 * ux_q;
			pb_s2 <= ay_s1 * uy_q;
			pc_s2 <= ax_s1 * uy_q;
			pd_s2 <= ay_s1 * ux_q;
		end
	end

	// s3: along-track and cross product
	logic signed [42:0] t_s3, cr_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3  <= 43'(pa_s2) + 43'(pb_s2);
			cr_s3 <= 43'(pc_s2) - 43'(pd_s2);
		end
	end

	// s4: perpendicular and cap distances, far flag
	logic signed [42:0] lent, along, perp;
	logic [28:0] perp_s4, along_s4;
	logic        kill_s4;
	assign lent  = $signed({5'b0, rt_q.root, 6'b0});
	assign perp  = cr_s3[42] ? -cr_s3 : cr_s3;

	always_comb begin
		if (t_s3 < 0) along = -t_s3;
		else if (t_s3 > lent) along = t_s3 - lent;
		else along = '0;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			perp_s4  <= perp[28:0];
			along_s4 <= along[28:0];
			kill_s4  <= lenz_q | (perp[42:29] != '0) | (along[42:29] != '0);
		end
	end

	// s5, s6: squared distance
	logic [57:0] sqp_s5, sqa_s5;
	logic        kill_s5, kill_s6;
	logic [58:0] d2_s6;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			sqp_s5  <= perp_s4 * perp_s4;
			sqa_s5  <= along_s4 * along_s4;
			kill_s5 <= kill_s4;
		end
		if (en[5]) begin
			d2_s6   <= 59'(sqp_s5) + 59'(sqa_s5);
			kill_s6 <= kill_s5;
		end
	end

	// s7..s12: pipelined root, SQ_ITER digits per stage
	logic [59:0] rrad_s [SQ_STAGES];
	sq_t         rst_s  [SQ_STAGES];
	logic        rkill_s[SQ_STAGES];

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_root
		logic [59:0] rad_in;
		sq_t         st_in;
		logic        kill_in;
		sq_t         st_out;

		if (j == 0) begin : g_first
			assign rad_in  = {1'b0, d2_s6};
			assign st_in   = '0;
			assign kill_in = kill_s6;
		end else begin : g_next
			assign rad_in  = rrad_s[j-1];
			assign st_in   = rst_s[j-1];
			assign kill_in = rkill_s[j-1];
		end

		always_comb begin
			st_out = st_in;
			for (int i = 0; i < SQ_ITER; i++) begin
				st_out = sqrt_step(st_out, rad_in[59-2*i -: 2]);
			end
		end

		always_ff @(posedge clk) begin
			if (en[SQ_FIRST+j]) begin
				rrad_s[j]  <= rad_in << (2 * SQ_ITER);
				rst_s[j]   <= st_out;
				rkill_s[j] <= kill_in;
			end
		end
	end

	// s13: coverage
	logic [12:0]        hwp;
	logic [28:0]        lim;
	logic signed [30:0] cov_raw;
	logic [21:0]        cov_s13;

	assign hwp     = ((thick_q >= 12'(ONE)) ? {1'b0, thick_q} : 13'(ONE)) + 13'(ONE);
	assign lim     = {hwp, 16'b0};
	assign cov_raw = $signed({2'b0, lim}) - $signed({1'b0, rst_s[SQ_STAGES-1].root[29:0]});

	always_ff @(posedge clk) begin
		if (en[NST-2]) begin
			if (rkill_s[SQ_STAGES-1] || cov_raw < 0) cov_s13 <= '0;
			else if (cov_raw > 31'(FULL_COV)) cov_s13 <= 22'(FULL_COV);
			else cov_s13 <= cov_raw[21:0];
		end
	end

	// s14: output register
	logic [29:0] aprod;
	logic [7:0]  alpha_s14;
	logic        draw;
	assign aprod = color_q[7:0] * cov_s13;

	always_ff @(posedge clk) begin
		if (en[NST-1]) alpha_s14 <= aprod[FRAC+24:FRAC+17];
	end

	assign draw     = (alpha_s14 != '0);
	assign m_tvalid = vld_q[NST-1];
	assign m_tuser  = draw;
	assign m_tdata  = {draw ? {alpha_s14, color_q[15:8], color_q[23:16], color_q[31:24]} : 32'd0,
	                   prow_q[NST-1], pcol_q[NST-1]};

endmodule
